>>> design/trbw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package trbw_pkg;

    // Default table dimensions.
    localparam int DEF_MAX_ENERGY_BINS = 16;
    localparam int DEF_MAX_COLUMNS     = 32;
    localparam int DEF_MAX_ROWS        = 32;

    // Register indexes on the configuration port.
    typedef enum logic [1:0] {
        REG_INTERP_ENABLE = 2'd0,
        REG_ENERGY_BINS   = 2'd1,
        REG_COLUMNS       = 2'd2,
        REG_ROWS          = 2'd3
    } trbw_reg_t;

    // Item kinds.
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Ratio cap of 100.0 in Q7.16 and the quotient width of the divider.
    localparam logic [6:0]  RATIO_CAP = 7'd100;
    localparam logic [22:0] CAP_Q16   = 23'd6553600;
    localparam int          QUOT_W    = 23;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       accept;
        logic       setup0;
        logic       setup1;
        logic       rd;
        logic       load;
        logic       div;
        logic       mac;
        logic [2:0] corner;
    } trbw_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic enable;
        logic cap_now;
        logic div_last;
    } trbw_status_t;

endpackage

`default_nettype wire

>>> design/trilinear_bin_ratio_weight.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Signals                                        Handshake
// --------  ---------------------------------------------  ----------------------------
// input     req_type entry_index entry_value energy_bin    taken when start && !busy
//           pixel_x pixel_y polarization offset_e/x/y
// result    weight                                         valid while done, one cycle
// config    cfg_we cfg_index cfg_data                      written when cfg_we is high
//
// A write item is stored in the bin table at the edge that takes it and
// gives no result; the block stays ready.
// A query with interpolation disabled has its result taken in the cycle
// after the query is taken. Otherwise the query passes through the setup
// states SETUP0 and SETUP1, then for each corner a table read, the weight
// products and the accumulation, with the shared one-bit-per-cycle divider
// run before the accumulation of each corner whose ratio is not capped.
// The next item can be taken in the cycle after the result.
// The eight corners pass one at a time through the single table port.
// Reset clears the configuration to its defaults and the controller to idle;
// the table contents are undefined until written. The receiver cannot stall,
// so each result is shown for exactly one cycle while done is high.

module trilinear_bin_ratio_weight #(
    parameter int MAX_ENERGY_BINS = trbw_pkg::DEF_MAX_ENERGY_BINS,
    parameter int MAX_COLUMNS     = trbw_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS        = trbw_pkg::DEF_MAX_ROWS
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    output logic                    done,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [5:0]         cfg_data,
    input  wire logic               req_type,
    input  wire logic [14:0]        entry_index,
    input  wire logic [31:0]        entry_value,
    input  wire logic [3:0]         energy_bin,
    input  wire logic [4:0]         pixel_x,
    input  wire logic [4:0]         pixel_y,
    input  wire logic               polarization,
    input  wire logic signed [15:0] offset_e,
    input  wire logic signed [15:0] offset_x,
    input  wire logic signed [15:0] offset_y,
    output logic [22:0]             weight
);
    import trbw_pkg::*;

    trbw_cmd_t    cmd;
    trbw_status_t status;

    // The controller sequences setup, the eight corner reads, the divider
    // and the accumulation; the datapath holds the table and arithmetic.
    trbw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy),
        .done     (done)
    );

    trbw_dp #(
        .MAX_ENERGY_BINS (MAX_ENERGY_BINS),
        .MAX_COLUMNS     (MAX_COLUMNS),
        .MAX_ROWS        (MAX_ROWS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req_type     (req_type),
        .entry_index  (entry_index),
        .entry_value  (entry_value),
        .energy_bin   (energy_bin),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .polarization (polarization),
        .offset_e     (offset_e),
        .offset_x     (offset_x),
        .offset_y     (offset_y),
        .weight       (weight)
    );

endmodule

`default_nettype wire

>>> design/trbw_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module trbw_dp #(
    parameter int MAX_ENERGY_BINS = trbw_pkg::DEF_MAX_ENERGY_BINS,
    parameter int MAX_COLUMNS     = trbw_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS        = trbw_pkg::DEF_MAX_ROWS
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire trbw_pkg::trbw_cmd_t  cmd,
    output trbw_pkg::trbw_status_t    status,
    input  wire logic                 cfg_we,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [5:0]           cfg_data,
    input  wire logic                 req_type,
    input  wire logic [14:0]          entry_index,
    input  wire logic [31:0]          entry_value,
    input  wire logic [3:0]           energy_bin,
    input  wire logic [4:0]           pixel_x,
    input  wire logic [4:0]           pixel_y,
    input  wire logic                 polarization,
    input  wire logic signed [15:0]   offset_e,
    input  wire logic signed [15:0]   offset_x,
    input  wire logic signed [15:0]   offset_y,
    output logic [22:0]               weight
);
    import trbw_pkg::*;

    localparam int DEPTH = 2 * MAX_ROWS * MAX_COLUMNS * MAX_ENERGY_BINS;
    localparam int AW    = $clog2(DEPTH);
    localparam int EW    = $clog2(MAX_ENERGY_BINS + 1);
    localparam int CW    = $clog2(MAX_COLUMNS + 1);
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int IEW   = (MAX_ENERGY_BINS > 1) ? $clog2(MAX_ENERGY_BINS) : 1;
    localparam int ICW   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int IRW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int SZ_W  = 10;
    localparam int ACC_W = 56;
    localparam logic [4:0] DIV_LAST = 5'(QUOT_W - 1);

    function automatic logic [SZ_W-1:0] fit_size(input logic [SZ_W-1:0] v,
                                                 input logic [SZ_W-1:0] m);
        logic [SZ_W-1:0] r;
        begin
            if (v == '0)
                r = SZ_W'(1);
            else if (v > m)
                r = m;
            else
                r = v;
            return r;
        end
    endfunction

    function automatic logic [SZ_W-1:0] clamp_idx(input logic [SZ_W-1:0] i,
                                                  input logic [SZ_W-1:0] n);
        return (i >= n) ? n - SZ_W'(1) : i;
    endfunction

    // Neighbor toward the sign of the offset, held at the edges.
    function automatic logic [SZ_W-1:0] nbr(input logic [SZ_W-1:0] i,
                                            input logic [SZ_W-1:0] n,
                                            input logic neg);
        logic [SZ_W-1:0] r;
        begin
            if (neg)
                r = (i == '0) ? '0 : i - SZ_W'(1);
            else
                r = (i + SZ_W'(1) >= n) ? n - SZ_W'(1) : i + SZ_W'(1);
            return r;
        end
    endfunction

    function automatic logic [16:0] mag16(input logic [15:0] r);
        return r[15] ? 17'h10000 - {1'b0, r} : {1'b0, r};
    endfunction

    // Configuration registers, held already fitted to their legal range.
    logic          en_reg;
    logic [EW-1:0] ebins_reg;
    logic [CW-1:0] cols_reg;
    logic [RW-1:0] rows_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg    <= 1'b1;
            ebins_reg <= EW'(fit_size(SZ_W'(16), SZ_W'(MAX_ENERGY_BINS)));
            cols_reg  <= CW'(fit_size(SZ_W'(32), SZ_W'(MAX_COLUMNS)));
            rows_reg  <= RW'(fit_size(SZ_W'(32), SZ_W'(MAX_ROWS)));
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_INTERP_ENABLE: en_reg <= cfg_data[0];
                REG_ENERGY_BINS:
                    ebins_reg <= EW'(fit_size(SZ_W'(cfg_data[4:0]),
                                              SZ_W'(MAX_ENERGY_BINS)));
                REG_COLUMNS:
                    cols_reg <= CW'(fit_size(SZ_W'(cfg_data), SZ_W'(MAX_COLUMNS)));
                REG_ROWS:
                    rows_reg <= RW'(fit_size(SZ_W'(cfg_data), SZ_W'(MAX_ROWS)));
                default: ;
            endcase
        end
    end

    // Address strides are registered from the size registers; rce_reg is built from ce_reg.
    logic [AW-1:0] ce_reg;
    logic [AW-1:0] rce_reg;

    always_ff @(posedge clk)
    begin
        ce_reg  <= AW'(32'(cols_reg) * 32'(ebins_reg));
        rce_reg <= AW'(32'(rows_reg) * 32'(ce_reg));
    end

    // Query fields latched when the item is taken.
    logic [3:0]  e_in_reg;
    logic [4:0]  x_in_reg;
    logic [4:0]  y_in_reg;
    logic        p_in_reg;
    logic [15:0] oe_reg;
    logic [15:0] ox_reg;
    logic [15:0] oy_reg;

    // Corner indices and blend factors: entry 0 is the centre side.
    logic [IEW-1:0] ei_reg [2];
    logic [ICW-1:0] xi_reg [2];
    logic [IRW-1:0] yi_reg [2];
    logic [16:0]    we_reg [2];
    logic [16:0]    wx_reg [2];
    logic [16:0]    wy_reg [2];
    logic [AW-1:0]  xb_reg [2];
    logic [AW-1:0]  yb_reg [2];
    logic [AW-1:0]  pb_reg;

    logic [SZ_W-1:0] e0, x0, y0;
    logic [16:0]     te, tx, ty;

    always_comb
    begin
        e0 = clamp_idx(SZ_W'(e_in_reg), SZ_W'(ebins_reg));
        x0 = clamp_idx(SZ_W'(x_in_reg), SZ_W'(cols_reg));
        y0 = clamp_idx(SZ_W'(y_in_reg), SZ_W'(rows_reg));
        te = mag16(oe_reg);
        tx = mag16(ox_reg);
        ty = mag16(oy_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            e_in_reg <= energy_bin;
            x_in_reg <= pixel_x;
            y_in_reg <= pixel_y;
            p_in_reg <= polarization;
            oe_reg   <= offset_e;
            ox_reg   <= offset_x;
            oy_reg   <= offset_y;
        end
        if (cmd.setup0)
        begin
            ei_reg[0] <= IEW'(e0);
            ei_reg[1] <= IEW'(nbr(e0, SZ_W'(ebins_reg), oe_reg[15]));
            xi_reg[0] <= ICW'(x0);
            xi_reg[1] <= ICW'(nbr(x0, SZ_W'(cols_reg), ox_reg[15]));
            yi_reg[0] <= IRW'(y0);
            yi_reg[1] <= IRW'(nbr(y0, SZ_W'(rows_reg), oy_reg[15]));
            we_reg[0] <= 17'h10000 - te;
            we_reg[1] <= te;
            wx_reg[0] <= 17'h10000 - tx;
            wx_reg[1] <= tx;
            wy_reg[0] <= 17'h10000 - ty;
            wy_reg[1] <= ty;
        end
        if (cmd.setup1)
        begin
            for (int i = 0; i < 2; i++)
            begin
                xb_reg[i] <= AW'(32'(xi_reg[i]) * 32'(ebins_reg));
                yb_reg[i] <= AW'(32'(yi_reg[i]) * 32'(ce_reg));
            end
            pb_reg <= p_in_reg ? rce_reg : '0;
        end
    end

    // Bin table: one port, written by write items, read once per corner.
    logic [31:0]   mem [DEPTH];
    logic [31:0]   rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          wr_ok;

    assign rd_addr = pb_reg + yb_reg[cmd.corner[2]] + xb_reg[cmd.corner[1]]
                   + AW'(ei_reg[cmd.corner[0]]);
    assign wr_ok   = cmd.accept && (req_type == REQ_WRITE)
                   && (32'(entry_index) < 32'(DEPTH));

    always_ff @(posedge clk)
    begin
        if (wr_ok)
            mem[AW'(entry_index)] <= entry_value;
        if (cmd.rd)
            rd_data_reg <= mem[rd_addr];
    end

    // Corner weight, ratio by restoring division, and accumulation.
    logic [33:0]      wyx_reg;
    logic [32:0]      w_reg;
    logic [31:0]      norm_reg;
    logic [31:0]      rem_reg;
    logic [QUOT_W-1:0] dq_reg;
    logic [4:0]       cnt_reg;
    logic             cap_reg;
    logic [ACC_W-1:0] acc_reg;

    logic [31:0]      nrm;
    logic [32:0]      trial;
    logic             ge;
    logic [22:0]      ratio;
    logic [54:0]      prod;

    always_comb
    begin
        nrm   = (cmd.corner == 3'd0) ? rd_data_reg : norm_reg;
        trial = {rem_reg, dq_reg[QUOT_W-1]};
        ge    = trial >= {1'b0, norm_reg};
        ratio = cap_reg ? CAP_Q16 : dq_reg;
        prod  = w_reg[32] ? {ratio, 32'd0} : 55'(ratio * w_reg[31:0]);
    end

    assign status.enable   = en_reg;
    assign status.cap_now  = {7'd0, rd_data_reg} >= 39'(nrm) * 39'(RATIO_CAP);
    assign status.div_last = cnt_reg == DIV_LAST;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            acc_reg <= en_reg ? '0 : ACC_W'(1) << 48;
        if (cmd.rd)
            wyx_reg <= wy_reg[cmd.corner[2]] * wx_reg[cmd.corner[1]];
        if (cmd.load)
        begin
            if (cmd.corner == 3'd0)
                norm_reg <= rd_data_reg;
            cap_reg <= status.cap_now;
            rem_reg <= {7'd0, rd_data_reg[31:7]};
            dq_reg  <= {rd_data_reg[6:0], 16'd0};
            cnt_reg <= '0;
            if (wyx_reg[32])
                w_reg <= {we_reg[cmd.corner[0]], 16'd0};
            else
                w_reg <= 33'((49'(wyx_reg[31:0]) * 49'(we_reg[cmd.corner[0]])) >> 16);
        end
        if (cmd.div)
        begin
            rem_reg <= ge ? 32'(trial - {1'b0, norm_reg}) : trial[31:0];
            dq_reg  <= {dq_reg[QUOT_W-2:0], ge};
            cnt_reg <= cnt_reg + 5'd1;
        end
        if (cmd.mac)
            acc_reg <= acc_reg + ACC_W'(prod);
    end

    assign weight = acc_reg[54:32];

endmodule

`default_nettype wire

>>> design/trbw_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module trbw_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic                   req_type,
    input  wire trbw_pkg::trbw_status_t status,
    output trbw_pkg::trbw_cmd_t         cmd,
    output logic                        busy,
    output logic                        done
);
    import trbw_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_SETUP0 = 8'b0000_0010,
        S_SETUP1 = 8'b0000_0100,
        S_READ   = 8'b0000_1000,
        S_LOAD   = 8'b0001_0000,
        S_DIV    = 8'b0010_0000,
        S_MAC    = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } trbw_state_t;

    trbw_state_t state_reg, state_next;
    logic [2:0]  k_reg, k_next;

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start && req_type == REQ_QUERY)
                    state_next = status.enable ? S_SETUP0 : S_DONE;
            end
            S_SETUP0:
            begin
                k_next     = 3'd0;
                state_next = S_SETUP1;
            end
            S_SETUP1: state_next = S_READ;
            S_READ:   state_next = S_LOAD;
            S_LOAD:   state_next = status.cap_now ? S_MAC : S_DIV;
            S_DIV:
            begin
                if (status.div_last)
                    state_next = S_MAC;
            end
            S_MAC:
            begin
                k_next     = k_reg + 3'd1;
                state_next = (k_reg == 3'd7) ? S_DONE : S_READ;
            end
            S_DONE:   state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    assign busy = state_reg != S_IDLE;
    assign done = state_reg == S_DONE;

    always_comb
    begin
        cmd.accept = (state_reg == S_IDLE) && start;
        cmd.setup0 = state_reg == S_SETUP0;
        cmd.setup1 = state_reg == S_SETUP1;
        cmd.rd     = state_reg == S_READ;
        cmd.load   = state_reg == S_LOAD;
        cmd.div    = state_reg == S_DIV;
        cmd.mac    = state_reg == S_MAC;
        cmd.corner = k_reg;
    end

`ifndef SYNTHESIS
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req_type == REQ_QUERY) |=> busy)
        else $error("query item taken but block not busy");

    a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held longer than one cycle");

    a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MAC && k_reg == 3'd7) |=> done)
        else $error("last corner accumulated without a result");

    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req_type == REQ_WRITE) |=> !busy)
        else $error("write item left the block busy");
`endif

endmodule

`default_nettype wire

>>> bench/tb_trilinear_bin_ratio_weight.sv
`timescale 1ns / 1ps

// Self-checking bench for the trilinear bin-ratio weight block.
//
// An initial block sets the size and enable registers for each phase and
// fills a queue of pending items. Every query is preceded by writes to
// any of its eight corner bins that have not been written yet, so the block
// never reads an undefined table entry. A driver at the falling edge
// presents the oldest pending item, and a monitor at the rising edge sees
// items being taken, keeps its own copy of the bin table, and computes the
// expected weight of each query. Each done strobe is compared with the
// oldest expected weight.

module tb_trilinear_bin_ratio_weight;
    import trbw_pkg::*;

    localparam int TABLE_DEPTH = 2 * DEF_MAX_ROWS * DEF_MAX_COLUMNS * DEF_MAX_ENERGY_BINS;
    localparam int STALL_LIMIT = 5000;

    typedef struct {
        logic               kind;
        logic [14:0]        index;
        logic [31:0]        value;
        logic [3:0]         ebin;
        logic [4:0]         px;
        logic [4:0]         py;
        logic               pol;
        logic signed [15:0] oe;
        logic signed [15:0] ox;
        logic signed [15:0] oy;
    } bin_item_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               done;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_index = '0;
    logic [5:0]         cfg_data = '0;
    logic               req_type = 1'b0;
    logic [14:0]        entry_index = '0;
    logic [31:0]        entry_value = '0;
    logic [3:0]         energy_bin = '0;
    logic [4:0]         pixel_x = '0;
    logic [4:0]         pixel_y = '0;
    logic               polarization = 1'b0;
    logic signed [15:0] offset_e = '0;
    logic signed [15:0] offset_x = '0;
    logic signed [15:0] offset_y = '0;
    logic [22:0]        weight;

    // Shadow of the block's state and registers.
    logic [31:0] bin_mem [0:TABLE_DEPTH-1];
    bit          bin_set [0:TABLE_DEPTH-1];
    bit          interp_on = 1'b1;
    int          n_ebins = DEF_MAX_ENERGY_BINS;
    int          n_cols = DEF_MAX_COLUMNS;
    int          n_rows = DEF_MAX_ROWS;

    bin_item_t   pending[$];
    logic [22:0] expected_weights[$];
    logic        took = 1'b0;
    int          idle_pct = 0;
    int          errors = 0;
    int          n_writes = 0;
    int          n_queries = 0;
    int          n_checked = 0;
    int          stall_cycles = 0;

    trilinear_bin_ratio_weight dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .done         (done),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req_type     (req_type),
        .entry_index  (entry_index),
        .entry_value  (entry_value),
        .energy_bin   (energy_bin),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .polarization (polarization),
        .offset_e     (offset_e),
        .offset_x     (offset_x),
        .offset_y     (offset_y),
        .weight       (weight)
    );

    always #2 clk = ~clk;

    // A size register value of zero acts as one; anything above the maximum
    // acts as the maximum.
    function automatic int fit_size(input int v, input int maxv);
        if (v < 1) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic int clamp_index(input int i, input int n);
        return (i >= n) ? n - 1 : i;
    endfunction

    // Neighbour in the direction of the offset's sign, held at the edges.
    function automatic int step_toward(input int i, input int n, input logic signed [15:0] off);
        if (off[15]) return (i == 0) ? 0 : i - 1;
        return (i + 1 >= n) ? n - 1 : i + 1;
    endfunction

    // Offset magnitude in Q0.16; the most negative code counts as one half.
    function automatic longint unsigned offset_mag(input logic signed [15:0] off);
        if (off[15]) return 64'd65536 - {48'd0, off};
        return {48'd0, off};
    endfunction

    // Table address of corner k: bit 2 picks the row neighbour, bit 1 the
    // column neighbour, bit 0 the energy neighbour. Corner 0 is the centre.
    function automatic int corner_addr(input bin_item_t it, input int k);
        int e0;
        int x0;
        int y0;
        int e;
        int x;
        int y;
        e0 = clamp_index(int'(it.ebin), n_ebins);
        x0 = clamp_index(int'(it.px), n_cols);
        y0 = clamp_index(int'(it.py), n_rows);
        e = k[0] ? step_toward(e0, n_ebins, it.oe) : e0;
        x = k[1] ? step_toward(x0, n_cols, it.ox) : x0;
        y = k[2] ? step_toward(y0, n_rows, it.oy) : y0;
        return ((int'(it.pol) * n_rows + y) * n_cols + x) * n_ebins + e;
    endfunction

    function automatic logic [22:0] blended_weight(input bin_item_t it);
        longint unsigned centre;
        longint unsigned c;
        longint unsigned r;
        longint unsigned w;
        longint unsigned acc;
        longint unsigned te;
        longint unsigned tx;
        longint unsigned ty;
        longint unsigned we;
        longint unsigned wx;
        longint unsigned wy;
        if (!interp_on) return 23'd65536;
        te = offset_mag(it.oe);
        tx = offset_mag(it.ox);
        ty = offset_mag(it.oy);
        centre = 64'(bin_mem[corner_addr(it, 0)]);
        acc = 0;
        for (int k = 0; k < 8; k++) begin
            c = 64'(bin_mem[corner_addr(it, k)]);
            // Ratios cap at 100.0, which also covers an empty centre bin.
            if (c >= 100 * centre) r = 64'(CAP_Q16);
            else r = (c << 16) / centre;
            we = k[0] ? te : 65536 - te;
            wx = k[1] ? tx : 65536 - tx;
            wy = k[2] ? ty : 65536 - ty;
            w = (wy * wx * we) >> 16;
            acc += r * w;
        end
        return acc[54:32];
    endfunction

    // Bin contents: mostly modest counts so ratios spread below the cap,
    // with empty bins and very large counts mixed in.
    function automatic logic [31:0] pick_count();
        case ($urandom_range(9))
            0: return 32'd0;
            1: return $urandom();
            2: return 32'hFFFF_FFFF - $urandom_range(3);
            default: return $urandom_range(2000, 1);
        endcase
    endfunction

    function automatic logic signed [15:0] pick_offset();
        case ($urandom_range(7))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic add_write(input int addr, input logic [31:0] val);
        bin_item_t it;
        it = '{default: '0};
        it.kind = REQ_WRITE;
        it.index = 15'(addr);
        it.value = val;
        // Noise in the unused energy bin, pixel x and energy offset fields keeps those input bits moving.
        it.ebin = 4'($urandom());
        it.px = 5'($urandom());
        it.oe = 16'($urandom());
        if (addr < TABLE_DEPTH) bin_set[addr] = 1'b1;
        pending.push_back(it);
    endtask

    // Queues a query, writing any corner bin that is still undefined first.
    task automatic add_query(input bin_item_t it);
        int a;
        it.kind = REQ_QUERY;
        it.index = 15'($urandom());
        it.value = $urandom();
        for (int k = 0; k < 8; k++) begin
            a = corner_addr(it, k);
            if (!bin_set[a]) add_write(a, pick_count());
        end
        pending.push_back(it);
    endtask

    task automatic add_random_query();
        bin_item_t it;
        it = '{default: '0};
        it.ebin = 4'($urandom());
        it.px = 5'($urandom());
        it.py = 5'($urandom());
        it.pol = 1'($urandom());
        it.oe = pick_offset();
        it.ox = pick_offset();
        it.oy = pick_offset();
        add_query(it);
    endtask

    task automatic write_reg(input trbw_reg_t idx, input logic [5:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_INTERP_ENABLE: interp_on = val[0];
            REG_ENERGY_BINS:   n_ebins = fit_size(int'(val[4:0]), DEF_MAX_ENERGY_BINS);
            REG_COLUMNS:       n_cols = fit_size(int'(val), DEF_MAX_COLUMNS);
            REG_ROWS:          n_rows = fit_size(int'(val), DEF_MAX_ROWS);
            default:           ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Waits until every item has been taken and every weight has come back.
    // Writes give no result, so it then lets the clock run on before registers move.
    task automatic drain();
        do @(posedge clk);
        while (pending.size() != 0 || expected_weights.size() != 0 || busy);
        repeat (20) @(posedge clk);
    endtask

    task automatic run_phase(input int pct, input int n_items);
        idle_pct = pct;
        while (pending.size() < n_items) begin
            // A small share of stray writes anywhere in the address space.
            if ($urandom_range(9) == 0) add_write($urandom_range(32767), $urandom());
            else add_random_query();
        end
        drain();
    endtask

    // Driver: holds an item on the inputs until it is taken, then moves on.
    always @(negedge clk) begin
        bin_item_t it;
        if (took) void'(pending.pop_front());
        if (rst_n && pending.size() != 0
                && ((start && !took) || $urandom_range(99) >= idle_pct)) begin
            it = pending[0];
            start <= 1'b1;
            req_type <= it.kind;
            entry_index <= it.index;
            entry_value <= it.value;
            energy_bin <= it.ebin;
            pixel_x <= it.px;
            pixel_y <= it.py;
            polarization <= it.pol;
            offset_e <= it.oe;
            offset_x <= it.ox;
            offset_y <= it.oy;
        end else begin
            start <= 1'b0;
        end
    end

    // Monitor: checks results first, then records the item taken at this
    // edge, so a result and a new item on the same edge stay in order.
    always @(posedge clk) begin
        bin_item_t it;
        logic [22:0] want;
        if (rst_n) begin
            if (done) begin
                n_checked++;
                if (expected_weights.size() == 0) begin
                    errors++;
                    $display("%0t: weight %0d arrived with no query outstanding",
                             $time, weight);
                end else begin
                    want = expected_weights.pop_front();
                    if (weight !== want) begin
                        errors++;
                        $display("%0t: weight mismatch, expected %0d, actual %0d",
                                 $time, want, weight);
                    end
                end
            end
            if (start && !busy) begin
                it = pending[0];
                if (it.kind == REQ_WRITE) begin
                    n_writes++;
                    bin_mem[it.index] = it.value;
                end else begin
                    n_queries++;
                    expected_weights.push_back(blended_weight(it));
                end
            end
            took <= start && !busy;
            stall_cycles = (done || (start && !busy)) ? 0 : stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        bin_item_t it;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part at the default sizes: extreme counts at both ends
        // of the table, an empty centre bin, corners held at every edge, and
        // the most negative and most positive offsets.
        add_write(0, 32'd0);
        add_write(TABLE_DEPTH - 1, 32'hFFFF_FFFF);
        it = '{default: '0};
        it.oe = 16'sh8000;
        it.ox = 16'sh8000;
        it.oy = 16'sh8000;
        add_query(it);
        it = '{ebin: 4'hF, px: 5'h1F, py: 5'h1F, pol: 1'b1, oe: 16'sh7FFF,
                ox: 16'sh7FFF, oy: 16'sh7FFF, default: '0};
        add_query(it);
        it.oe = 16'sh8000;
        it.ox = 16'sh0000;
        it.oy = 16'sh4000;
        add_query(it);
        add_write(100, 32'd1);
        add_write(101, 32'd200);
        it = '{ebin: 4'd4, default: '0};
        it.oe = 16'sh7FFF;
        add_query(it);
        for (int i = 0; i < 6; i++) add_random_query();
        drain();

        // Random phases over several register settings and idle rates.
        run_phase(0, 220);
        write_reg(REG_ENERGY_BINS, 6'd0);
        write_reg(REG_COLUMNS, 6'd0);
        write_reg(REG_ROWS, 6'd0);
        run_phase(66, 120);
        write_reg(REG_ENERGY_BINS, 6'd31);
        write_reg(REG_COLUMNS, 6'd63);
        write_reg(REG_ROWS, 6'd63);
        run_phase(20, 200);
        write_reg(REG_INTERP_ENABLE, 6'd0);
        run_phase(66, 120);
        write_reg(REG_INTERP_ENABLE, 6'd1);
        write_reg(REG_ENERGY_BINS, 6'd3);
        write_reg(REG_COLUMNS, 6'd4);
        write_reg(REG_ROWS, 6'd5);
        run_phase(0, 200);
        write_reg(REG_ENERGY_BINS, 6'd16);
        write_reg(REG_COLUMNS, 6'd32);
        write_reg(REG_ROWS, 6'd1);
        run_phase(20, 180);

        $display("Covered %0d table writes and %0d weight queries, %0d weights checked,",
                 n_writes, n_queries, n_checked);
        $display("across default, minimum, clamped and small sizes, with blending on and off.");
        if (errors == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

endmodule
